### hw/rtl/ura_pkg.sv
// Shared types and constants for the ultrasonic range averager.
// Used by every module of the block; has no dependencies of its own.

package ura_pkg;

   // Field widths.
   localparam int unsigned TRIG_W  = 10;
   localparam int unsigned GAP_W   = 16;
   localparam int unsigned PULSE_W = 16;
   localparam int unsigned DIST_W  = 14;

   // Configuration port.
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIGGER_TICKS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_TICKS     = 2'd1;

   localparam logic [TRIG_W-1:0] TRIGGER_TICKS_RESET = 10'd10;
   localparam logic [GAP_W-1:0]  GAP_TICKS_RESET     = 16'd5000;

   // Echo width counter holds at its maximum.
   localparam logic [PULSE_W-1:0] PULSE_MAX = {PULSE_W{1'b1}};

   // Distance per tick is 34/200 = 17/100 mm. The product with 17 is exact
   // in 21 bits; the divide by 100 is a multiply by ceil(2^28/100), which
   // is exact for every dividend below 2^21.
   localparam int unsigned P17_W       = PULSE_W + 5;
   localparam int unsigned RECIP_W     = 22;
   localparam int unsigned RECIP_SHIFT = 28;
   localparam logic [RECIP_W-1:0] RECIP_100 = 22'd2684355;
   localparam int unsigned PROD_W      = P17_W + RECIP_W;

   // Depth of the queue between the sequencer and the distance pipeline.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      PH_TRIG = 4'b0001,
      PH_WAIT = 4'b0010,
      PH_MEAS = 4'b0100,
      PH_GAP  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [TRIG_W-1:0] trigger_ticks;
      logic [GAP_W-1:0]  gap_ticks;
   } cfg_type;

   // One tick as classified by the sequencer.
   typedef struct packed {
      logic               trigger_level;
      logic               sample_done;
      logic [PULSE_W-1:0] pulse_ticks;
   } tick_type;

endpackage

### hw/rtl/ultrasonic_range_averager_top.sv
// Top level of the ultrasonic range averager.
// Depends on ura_pkg, ura_front, ura_queue and ura_back.

// Each input word is one 1 us tick carrying the sampled echo level, and each
// accepted word yields exactly one result word, in order: the trigger level to
// drive for that tick, a flag that marks the tick completing an average, and
// the latest averaged distance in millimetres (zero until the first average).
// The sequencer drives trigger for trigger_ticks ticks (zero counts as one),
// waits for echo to rise, counts echo-high ticks with saturation at 65535,
// converts the width to floor(width*34/200) mm when echo falls, then pauses
// gap_ticks ticks. After 2^SAMPLE_LOG2 samples the sum shifted right by
// SAMPLE_LOG2 is presented. The block takes one word per clock: the sequencer
// handles each accepted tick as it comes and the distance path is pipelined,
// so throughput is one word per cycle as long as rsp_stall is low. A result
// word is registered in turn in the queue, the multiply-by-17 stage, the
// reciprocal divide stage and the output register. A four-word
// queue sits between sequencer and pipeline; req_stall rises only when it is
// full. Configuration registers (index 0 trigger_ticks, index 1 gap_ticks)
// are written through csr_wr_en, csr_index and csr_wdata; other indexes are
// ignored, and writes should be made while the block is idle.

module ultrasonic_range_averager_top
   import ura_pkg::*;
#(
   parameter int unsigned SAMPLE_LOG2 = 6
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_echo_level,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_trigger_level,
   output logic                   rsp_distance_valid,
   output logic [DIST_W-1:0]      rsp_distance_mm
);

   cfg_type  cfg_ff;
   logic     queue_full, queue_avail, queue_pop, front_push;
   tick_type front_word, queue_word;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_ticks <= TRIGGER_TICKS_RESET;
         cfg_ff.gap_ticks     <= GAP_TICKS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TRIGGER_TICKS: cfg_ff.trigger_ticks <= csr_wdata[TRIG_W-1:0];
            CSR_GAP_TICKS:     cfg_ff.gap_ticks     <= csr_wdata[GAP_W-1:0];
            default: ;
         endcase
      end
   end

   // A tick is accepted whenever the queue has room.
   assign req_stall = queue_full;

   ura_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .tick_valid (req_valid && !queue_full),
      .tick_echo  (req_echo_level),
      .push       (front_push),
      .push_data  (front_word)
   );

   ura_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_word),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_avail),
      .pop_data  (queue_word)
   );

   ura_back #(
      .SAMPLE_LOG2 (SAMPLE_LOG2)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .word_avail         (queue_avail),
      .word               (queue_word),
      .pop                (queue_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_trigger_level  (rsp_trigger_level),
      .rsp_distance_valid (rsp_distance_valid),
      .rsp_distance_mm    (rsp_distance_mm)
   );

endmodule

### hw/rtl/ura_front.sv
// Tick sequencer: trigger, wait, measure and gap phases of the ranger.
// Depends on ura_pkg; feeds classified ticks to ura_queue.

module ura_front
   import ura_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     tick_valid,
   input  logic     tick_echo,
   output logic     push,
   output tick_type push_data
);

   phase_type          phase_ff, phase_in;
   logic [GAP_W-1:0]   timer_ff, timer_in;
   logic [PULSE_W-1:0] pulse_ff, pulse_in;
   logic [GAP_W:0]     timer_inc;
   logic [TRIG_W-1:0]  trig_len;

   assign timer_inc = {1'b0, timer_ff} + 1'b1;
   assign trig_len  = (cfg.trigger_ticks == '0) ? TRIG_W'(1) : cfg.trigger_ticks;

   always_comb begin
      phase_in  = phase_ff;
      timer_in  = timer_ff;
      pulse_in  = pulse_ff;
      push_data.trigger_level = 1'b0;
      push_data.sample_done   = 1'b0;
      push_data.pulse_ticks   = pulse_ff;
      unique case (phase_ff)
         PH_TRIG: begin
            push_data.trigger_level = 1'b1;
            timer_in = timer_inc[GAP_W-1:0];
            if (timer_inc >= (GAP_W+1)'(trig_len)) begin
               phase_in = PH_WAIT;
               timer_in = '0;
            end
         end
         PH_WAIT: begin
            if (tick_echo) begin
               phase_in = PH_MEAS;
               pulse_in = PULSE_W'(1);
            end
         end
         PH_MEAS: begin
            if (tick_echo) begin
               if (pulse_ff != PULSE_MAX) begin
                  pulse_in = pulse_ff + 1'b1;
               end
            end else begin
               push_data.sample_done = 1'b1;
               pulse_in = '0;
               timer_in = '0;
               phase_in = (cfg.gap_ticks == '0) ? PH_TRIG : PH_GAP;
            end
         end
         PH_GAP: begin
            timer_in = timer_inc[GAP_W-1:0];
            if (timer_inc >= {1'b0, cfg.gap_ticks}) begin
               phase_in = PH_TRIG;
               timer_in = '0;
            end
         end
         default: begin
            phase_in = PH_TRIG;
            timer_in = '0;
         end
      endcase
   end

   assign push = tick_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TRIG;
         timer_ff <= '0;
         pulse_ff <= '0;
      end else if (tick_valid) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         pulse_ff <= pulse_in;
      end
   end

endmodule

### hw/rtl/ura_queue.sv
// Small register queue between the tick sequencer and the distance pipeline.
// Depends on ura_pkg for the entry type and depth.

module ura_queue
   import ura_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  tick_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output tick_type pop_data
);

   tick_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                    do_push, do_pop;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue count exceeds depth");

   a_count_push: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a push");

endmodule

### hw/rtl/ura_back.sv
// Distance pipeline: converts echo widths to millimetres, averages them and
// holds the result word. Depends on ura_pkg; pops words from ura_queue.

module ura_back
   import ura_pkg::*;
#(
   parameter int unsigned SAMPLE_LOG2 = 6
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              word_avail,
   input  tick_type          word,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_trigger_level,
   output logic              rsp_distance_valid,
   output logic [DIST_W-1:0] rsp_distance_mm
);

   localparam int unsigned SUM_W = DIST_W + SAMPLE_LOG2;
   localparam int unsigned IDX_W = SAMPLE_LOG2 + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'((1 << SAMPLE_LOG2) - 1);

   logic advance;

   // Stage 1: width times 17.
   logic             s1_valid_ff, s1_trig_ff, s1_done_ff;
   logic [P17_W-1:0] s1_p17_ff;
   // Stage 2: divide by 100 through the reciprocal.
   logic              s2_valid_ff, s2_trig_ff, s2_done_ff;
   logic [DIST_W-1:0] s2_mm_ff;
   logic [PROD_W-1:0] product;
   // Averaging state and result word.
   logic [SUM_W-1:0]  sum_ff, sum_in, sum_add;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [DIST_W-1:0] last_ff, last_in;
   logic              avg_done;
   logic              out_valid_ff, out_trig_ff, out_dvalid_ff;

   assign advance = !out_valid_ff || !rsp_stall;
   assign pop     = advance && word_avail;
   assign product = PROD_W'(s1_p17_ff) * PROD_W'(RECIP_100);
   assign sum_add = sum_ff + SUM_W'(s2_mm_ff);

   always_comb begin
      sum_in   = sum_ff;
      idx_in   = idx_ff;
      last_in  = last_ff;
      avg_done = 1'b0;
      if (s2_valid_ff && s2_done_ff) begin
         if (idx_ff == LAST_IDX) begin
            avg_done = 1'b1;
            last_in  = sum_add[SAMPLE_LOG2 +: DIST_W];
            sum_in   = '0;
            idx_in   = '0;
         end else begin
            sum_in = sum_add;
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_trig_ff  <= word.trigger_level;
         s1_done_ff  <= word.sample_done;
         s1_p17_ff   <= (P17_W'(word.pulse_ticks) << 4) + P17_W'(word.pulse_ticks);
         s2_trig_ff  <= s1_trig_ff;
         s2_done_ff  <= s1_done_ff;
         s2_mm_ff    <= product[RECIP_SHIFT +: DIST_W];
         out_trig_ff <= s2_trig_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         out_dvalid_ff <= 1'b0;
         sum_ff        <= '0;
         idx_ff        <= '0;
         last_ff       <= '0;
      end else if (advance) begin
         s1_valid_ff   <= word_avail;
         s2_valid_ff   <= s1_valid_ff;
         out_valid_ff  <= s2_valid_ff;
         out_dvalid_ff <= avg_done;
         sum_ff        <= sum_in;
         idx_ff        <= idx_in;
         last_ff       <= last_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_trigger_level  = out_trig_ff;
   assign rsp_distance_valid = out_dvalid_ff;
   assign rsp_distance_mm    = last_ff;

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= LAST_IDX)
      else $error("sample index past the averaging window");

   a_avg_clears: assert property (@(posedge clock) disable iff (reset)
      out_dvalid_ff |-> (idx_ff == '0 && sum_ff == '0))
      else $error("average presented without clearing the running sum");

endmodule

### test/tb_top.sv
// Self-checking testbench for ultrasonic_range_averager_top: a tick-level predictor of
// the trigger/echo sequencer and the distance averager, with a checker that
// compares every result word. Depends on ura_pkg and the top level of the block only.
`timescale 1ns / 1ps

module tb_top;
   import ura_pkg::*;

   // The averaging window of the block under test, 2^AVG_LOG2 samples.
   localparam int unsigned AVG_LOG2 = 6;
   localparam int unsigned SAMPLES  = 1 << AVG_LOG2;
   localparam int unsigned SUM_W    = DIST_W + AVG_LOG2;

   // Echo width to millimetres is width * 34 / 200, rounded down.
   localparam int unsigned MM_NUM = 34;
   localparam int unsigned MM_DEN = 200;

   // Indexes past the two real registers; the block must ignore writes to them.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   localparam int unsigned RESET_CYCLES = 5;
   // Three pipeline stages plus the four-word queue, with margin.
   localparam int unsigned DRAIN_CYCLES = 12;
   // Longest stretch without any handshake that the watchdog allows.
   localparam int unsigned QUIET_LIMIT  = 400;
   localparam int unsigned MAX_IDLE     = 6;
   localparam int unsigned RANDOM_TICKS = 700;
   localparam int unsigned REPORT_CAP   = 100;

   // One result word as the block should present it.
   typedef struct packed {
      logic              trigger_level;
      logic              distance_valid;
      logic [DIST_W-1:0] distance_mm;
   } tick_out_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_echo_level = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_trigger_level;
   logic                   rsp_distance_valid;
   logic [DIST_W-1:0]      rsp_distance_mm;

   ultrasonic_range_averager_top #(
      .SAMPLE_LOG2(AVG_LOG2)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_echo_level     (req_echo_level),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_trigger_level  (rsp_trigger_level),
      .rsp_distance_valid (rsp_distance_valid),
      .rsp_distance_mm    (rsp_distance_mm)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 0;
   end

   // ------------------------------------------------------------------------
   // Predictor state. It mirrors the sequencer and the averager and starts at
   // the reset values of the block. The stimulus also looks at seq_phase to
   // shape echo pulses that answer the trigger.
   // ------------------------------------------------------------------------
   logic [TRIG_W-1:0]   cfg_trigger    = TRIGGER_TICKS_RESET;
   logic [GAP_W-1:0]    cfg_gap        = GAP_TICKS_RESET;
   phase_type           seq_phase      = PH_TRIG;
   logic [GAP_W-1:0]    seq_timer      = '0;
   logic [PULSE_W-1:0]  echo_width     = '0;
   logic [SUM_W-1:0]    mm_sum         = '0;
   logic [AVG_LOG2:0]   samples_in_sum = '0;
   logic [DIST_W-1:0]   avg_mm         = '0;

   // Result words owed by the block, oldest first.
   tick_out_type awaited_outputs[$];

   int  mismatches      = 0;
   int  checked_words   = 0;
   int  sent_ticks      = 0;
   int  stall_hold      = 0;
   bit  sender_pauses   = 1'b1;
   bit  receiver_stalls = 1'b1;

   // Advances the predictor by one tick and returns the word it should yield.
   function automatic tick_out_type ranger_tick(input logic echo);
      tick_out_type      word;
      logic [GAP_W:0]    next_timer;
      logic [TRIG_W-1:0] trig_len;
      int unsigned       sample_mm;
      word = '0;
      // A zero trigger length still gives one tick of trigger.
      trig_len = (cfg_trigger == '0) ? TRIG_W'(1) : cfg_trigger;
      next_timer = {1'b0, seq_timer} + 1'b1;
      case (seq_phase)
         PH_TRIG: begin
            word.trigger_level = 1'b1;
            if (next_timer >= trig_len) begin
               seq_phase = PH_WAIT;
               seq_timer = '0;
            end else begin
               seq_timer = next_timer[GAP_W-1:0];
            end
         end
         PH_WAIT: begin
            // The rising tick already counts as the first tick of the pulse.
            if (echo) begin
               seq_phase  = PH_MEAS;
               echo_width = PULSE_W'(1);
            end
         end
         PH_MEAS: begin
            if (echo) begin
               if (echo_width != PULSE_MAX)
                  echo_width = echo_width + 1'b1;
            end else begin
               sample_mm = (echo_width * MM_NUM) / MM_DEN;
               mm_sum = mm_sum + SUM_W'(sample_mm);
               echo_width = '0;
               samples_in_sum = samples_in_sum + 1'b1;
               if (samples_in_sum == SAMPLES) begin
                  avg_mm = DIST_W'(mm_sum >> AVG_LOG2);
                  word.distance_valid = 1'b1;
                  mm_sum = '0;
                  samples_in_sum = '0;
               end
               seq_timer = '0;
               seq_phase = (cfg_gap == '0) ? PH_TRIG : PH_GAP;
            end
         end
         PH_GAP: begin
            if (next_timer >= cfg_gap) begin
               seq_phase = PH_TRIG;
               seq_timer = '0;
            end else begin
               seq_timer = next_timer[GAP_W-1:0];
            end
         end
         default: ;
      endcase
      word.distance_mm = avg_mm;
      return word;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      // Past the cap the count still goes up, but the log stays readable.
      if (mismatches < REPORT_CAP)
         $display("ERROR: result word %0d, %s: got %0d, expected %0d",
                  checked_words, what, got, want);
      mismatches++;
   endtask

   // ------------------------------------------------------------------------
   // Sender. Every call starts and returns at a rising edge. Valid is only
   // lowered when a pause is drawn, so back-to-back words keep it high without
   // a second assignment in the same step. The expected word is queued at the
   // edge where the tick is accepted.
   // ------------------------------------------------------------------------
   task automatic send_tick(input logic echo);
      int pause;
      pause = sender_pauses ? $urandom_range(0, MAX_IDLE) : 0;
      if (pause > 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_echo_level <= echo;
      do
         @(posedge clock);
      while (req_stall);
      awaited_outputs.push_back(ranger_tick(echo));
      sent_ticks++;
   endtask

   // One full measurement: ride out trigger and gap with noise on the echo
   // line (it is ignored there), hold echo low for a while, then a pulse of
   // the given width and the falling tick that closes the sample.
   task automatic run_sample(input int unsigned width, input int unsigned delay);
      while (seq_phase != PH_WAIT)
         send_tick($urandom_range(0, 1));
      repeat (delay) send_tick(1'b0);
      repeat (width) send_tick(1'b1);
      send_tick(1'b0);
   endtask

   // Stops sending and waits until every owed word has come back, then lets
   // the pipeline run empty. Configuration writes happen only after this.
   task automatic settle();
      req_valid <= 1'b0;
      while (awaited_outputs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // A write is followed by an idle edge, which keeps two writes in a row
   // from assigning the enable twice in one step.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (index == CSR_TRIGGER_TICKS)
         cfg_trigger = value[TRIG_W-1:0];
      else if (index == CSR_GAP_TICKS)
         cfg_gap = value[GAP_W-1:0];
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Result side. Each accepted word is checked against the oldest expected
   // one, field by field. After every accepted word the receiver draws how many
   // cycles it holds stall high before taking the next one.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      tick_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_outputs.size() == 0) begin
            report_mismatch("word with none expected", 1, 0);
         end else begin
            want = awaited_outputs.pop_front();
            if (rsp_trigger_level !== want.trigger_level)
               report_mismatch("trigger_level", rsp_trigger_level, want.trigger_level);
            if (rsp_distance_valid !== want.distance_valid)
               report_mismatch("distance_valid", rsp_distance_valid, want.distance_valid);
            if (rsp_distance_mm !== want.distance_mm)
               report_mismatch("distance_mm", rsp_distance_mm, want.distance_mm);
         end
         checked_words++;
         stall_hold = receiver_stalls ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (stall_hold > 0) begin
         rsp_stall <= 1'b1;
         stall_hold--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Ends the run if neither channel completes a handshake for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("ERROR: no handshake for %0d cycles", QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   // Reset values: a ten-tick trigger, then a short echo, then a few ticks of
   // the 5000-tick gap. The gap is then cut to 3 while its timer already
   // stands at 5, so the gap must end on the very next tick.
   task automatic check_default_timing();
      run_sample(2, 1);
      repeat (5) send_tick($urandom_range(0, 1));
      settle();
      write_reg(CSR_GAP_TICKS, 16'd3);
      run_sample(1, 0);
   endtask

   // Register corner cases: ignored indexes, a zero trigger (one tick), a zero
   // gap (trigger follows the sample at once), a trigger written with data
   // bits set above its field, and a moderate gap run out in full. Finally
   // the gap drops to zero while the block sits at the start of a gap.
   task automatic check_register_edges();
      settle();
      write_reg(CSR_SPARE_A, 16'hFFFF);
      write_reg(CSR_SPARE_B, 16'h0001);
      write_reg(CSR_TRIGGER_TICKS, 16'd0);
      write_reg(CSR_GAP_TICKS, 16'd0);
      run_sample(1, 0);
      run_sample(6, 2);
      settle();
      write_reg(CSR_TRIGGER_TICKS, 16'hFC04);
      run_sample(3, 0);
      settle();
      write_reg(CSR_GAP_TICKS, 16'd40);
      run_sample(5, 0);
      run_sample(2, 1);
      settle();
      write_reg(CSR_GAP_TICKS, 16'd0);
      write_reg(CSR_TRIGGER_TICKS, 16'd1);
      run_sample(1, 0);
      run_sample(9, 1);
   endtask

   // Averaging window: close the running average first, then one 348-tick
   // pulse (59 mm) among short ones, so that the next average carries a large
   // known share and is presented on the last sample of the window.
   task automatic check_average_window();
      settle();
      write_reg(CSR_TRIGGER_TICKS, 16'd1);
      write_reg(CSR_GAP_TICKS, 16'd0);
      while (samples_in_sum != 0)
         run_sample($urandom_range(1, 5), $urandom_range(0, 1));
      run_sample(348, 1);
      repeat (SAMPLES - 1)
         run_sample($urandom_range(1, 5), $urandom_range(0, 1));
   endtask

   // Random traffic in phases, each with its own register setting written
   // while the block is idle (the sequencer keeps its state across the write).
   // Most samples are short so that many averages complete; a few long pulses
   // and long echo delays are mixed in. Some phases run with no pauses at all.
   task automatic check_random_traffic();
      int start_ticks;
      int phase_end;
      int samples_done;
      start_ticks  = sent_ticks;
      samples_done = 0;
      while (sent_ticks - start_ticks < RANDOM_TICKS) begin
         settle();
         write_reg(CSR_TRIGGER_TICKS, CSR_DATA_W'(($urandom_range(0, 7) == 0) ?
                   $urandom_range(4, 40) : $urandom_range(0, 3)));
         write_reg(CSR_GAP_TICKS, CSR_DATA_W'(($urandom_range(0, 7) == 0) ?
                   $urandom_range(4, 50) : $urandom_range(0, 3)));
         sender_pauses   = ($urandom_range(0, 3) != 0);
         receiver_stalls = ($urandom_range(0, 3) != 0);
         phase_end = sent_ticks + $urandom_range(150, 350);
         while (sent_ticks < phase_end) begin
            run_sample(($urandom_range(0, 7) == 0) ? $urandom_range(13, 220) :
                       $urandom_range(1, 12),
                       ($urandom_range(0, 11) == 0) ? $urandom_range(5, 40) :
                       $urandom_range(0, 2));
            samples_done++;
            // Now and then the sender holds off until the block has caught up.
            if (samples_done == 10 || $urandom_range(0, 24) == 0)
               settle();
         end
      end
      sender_pauses   = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      check_default_timing();
      check_register_edges();
      check_average_window();
      check_random_traffic();
      settle();
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
